[hdl/trcfa_pkg.sv]
`default_nettype none
package trcfa_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_B      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_C      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_BETA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_GAMMA = 3'd5;

    localparam logic [31:0] LEN_RESET  = 32'h0280_0000;
    localparam logic [63:0] TRIG_RESET = 64'h0000_0000_4000_0000;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [5:0] STEP_LAST = 6'd32;

    typedef struct packed {
        logic [31:0] len_a;
        logic [31:0] len_b;
        logic [31:0] len_c;
        logic [63:0] trig_alpha;
        logic [63:0] trig_beta;
        logic [63:0] trig_gamma;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] frac_dx;
        logic signed [31:0] frac_dy;
        logic signed [31:0] frac_dz;
        logic [31:0]        target_sq;
        logic [31:0]        weight;
        logic               last;
    } item_t;

    typedef enum logic [1:0] {SH24, SH26, SH28, SH30} shift_t;

    typedef enum logic [2:0] {
        OP_SET, OP_SET2, OP_NEG2, OP_ADD, OP_ADD2, OP_SUBR2
    } op_t;

    typedef enum logic [5:0] {
        SRC_ZERO, SRC_DX, SRC_DY, SRC_DZ, SRC_LA, SRC_LB, SRC_LC,
        SRC_CA, SRC_SA, SRC_CB, SRC_SB, SRC_CG, SRC_SG, SRC_W,
        SRC_X, SRC_Y, SRC_Z, SRC_XY, SRC_XZ, SRC_YZ, SRC_D, SRC_R, SRC_WR,
        SRC_PA, SRC_PB, SRC_PC,
        SRC_DT0, SRC_DT1, SRC_DT2, SRC_DT3, SRC_DT4, SRC_DT5,
        SRC_ACCT, SRC_ACCG0, SRC_ACCG1, SRC_ACCG2, SRC_ACCG3, SRC_ACCG4, SRC_ACCG5
    } src_t;

    typedef struct packed {
        op_t    op;
        src_t   dst;
        src_t   a;
        src_t   b;
        src_t   base;
        shift_t sh;
    } step_t;

    typedef enum logic [1:0] {MS_IDLE, MS_PROD, MS_ROUND, MS_DONE} mul_state_t;
    typedef enum logic [1:0] {BS_IDLE, BS_ISSUE, BS_WAIT, BS_EMIT} back_state_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_dbl(input logic signed [63:0] a);
        return sat_add(a, a);
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        return (a == S64_MIN) ? S64_MAX : -a;
    endfunction

    function automatic step_t mk(input op_t op, input src_t dst, input src_t a,
                                 input src_t b, input src_t base, input shift_t sh);
        step_t s;
        s.op = op; s.dst = dst; s.a = a; s.b = b; s.base = base; s.sh = sh;
        return s;
    endfunction

    // Microprogram for one restraint; sums keep the left-to-right order.
    function automatic step_t step_rom(input logic [5:0] idx);
        step_t s;
        case (idx)
            6'd0:  s = mk(OP_SET,   SRC_X,     SRC_DX, SRC_LA,  SRC_ZERO,  SH26);
            6'd1:  s = mk(OP_SET,   SRC_Y,     SRC_DY, SRC_LB,  SRC_ZERO,  SH26);
            6'd2:  s = mk(OP_SET,   SRC_Z,     SRC_DZ, SRC_LC,  SRC_ZERO,  SH26);
            6'd3:  s = mk(OP_SET,   SRC_XY,    SRC_X,  SRC_Y,   SRC_ZERO,  SH24);
            6'd4:  s = mk(OP_SET,   SRC_XZ,    SRC_X,  SRC_Z,   SRC_ZERO,  SH24);
            6'd5:  s = mk(OP_SET,   SRC_YZ,    SRC_Y,  SRC_Z,   SRC_ZERO,  SH24);
            6'd6:  s = mk(OP_SET,   SRC_D,     SRC_X,  SRC_X,   SRC_ZERO,  SH24);
            6'd7:  s = mk(OP_ADD,   SRC_D,     SRC_Y,  SRC_Y,   SRC_D,     SH24);
            6'd8:  s = mk(OP_ADD,   SRC_D,     SRC_Z,  SRC_Z,   SRC_D,     SH24);
            6'd9:  s = mk(OP_ADD2,  SRC_D,     SRC_XY, SRC_CG,  SRC_D,     SH30);
            6'd10: s = mk(OP_ADD2,  SRC_D,     SRC_XZ, SRC_CB,  SRC_D,     SH30);
            6'd11: s = mk(OP_ADD2,  SRC_D,     SRC_YZ, SRC_CA,  SRC_D,     SH30);
            6'd12: s = mk(OP_SUBR2, SRC_R,     SRC_ZERO, SRC_ZERO, SRC_D,  SH24);
            6'd13: s = mk(OP_SET,   SRC_WR,    SRC_W,  SRC_R,   SRC_ZERO,  SH24);
            6'd14: s = mk(OP_ADD,   SRC_PA,    SRC_Y,  SRC_CG,  SRC_X,     SH30);
            6'd15: s = mk(OP_ADD,   SRC_PA,    SRC_Z,  SRC_CB,  SRC_PA,    SH30);
            6'd16: s = mk(OP_ADD,   SRC_PB,    SRC_X,  SRC_CG,  SRC_Y,     SH30);
            6'd17: s = mk(OP_ADD,   SRC_PB,    SRC_Z,  SRC_CA,  SRC_PB,    SH30);
            6'd18: s = mk(OP_ADD,   SRC_PC,    SRC_X,  SRC_CB,  SRC_Z,     SH30);
            6'd19: s = mk(OP_ADD,   SRC_PC,    SRC_Y,  SRC_CA,  SRC_PC,    SH30);
            6'd20: s = mk(OP_SET2,  SRC_DT0,   SRC_DX, SRC_PA,  SRC_ZERO,  SH28);
            6'd21: s = mk(OP_SET2,  SRC_DT1,   SRC_DY, SRC_PB,  SRC_ZERO,  SH28);
            6'd22: s = mk(OP_SET2,  SRC_DT2,   SRC_DZ, SRC_PC,  SRC_ZERO,  SH28);
            6'd23: s = mk(OP_NEG2,  SRC_DT3,   SRC_YZ, SRC_SA,  SRC_ZERO,  SH30);
            6'd24: s = mk(OP_NEG2,  SRC_DT4,   SRC_XZ, SRC_SB,  SRC_ZERO,  SH30);
            6'd25: s = mk(OP_NEG2,  SRC_DT5,   SRC_XY, SRC_SG,  SRC_ZERO,  SH30);
            6'd26: s = mk(OP_ADD,   SRC_ACCT,  SRC_WR, SRC_R,   SRC_ACCT,  SH24);
            6'd27: s = mk(OP_ADD2,  SRC_ACCG0, SRC_WR, SRC_DT0, SRC_ACCG0, SH24);
            6'd28: s = mk(OP_ADD2,  SRC_ACCG1, SRC_WR, SRC_DT1, SRC_ACCG1, SH24);
            6'd29: s = mk(OP_ADD2,  SRC_ACCG2, SRC_WR, SRC_DT2, SRC_ACCG2, SH24);
            6'd30: s = mk(OP_ADD2,  SRC_ACCG3, SRC_WR, SRC_DT3, SRC_ACCG3, SH24);
            6'd31: s = mk(OP_ADD2,  SRC_ACCG4, SRC_WR, SRC_DT4, SRC_ACCG4, SH24);
            6'd32: s = mk(OP_ADD2,  SRC_ACCG5, SRC_WR, SRC_DT5, SRC_ACCG5, SH24);
            default: s = mk(OP_SET, SRC_ZERO,  SRC_ZERO, SRC_ZERO, SRC_ZERO, SH24);
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[hdl/trcfa_front.sv]
`default_nettype none
module trcfa_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [31:0]             frac_dx,
    input  wire logic signed [31:0]             frac_dy,
    input  wire logic signed [31:0]             frac_dz,
    input  wire logic [31:0]                    target_sq,
    input  wire logic [31:0]                    weight,
    input  wire logic                           last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [trcfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data,
    output logic                                item_valid,
    input  wire logic                           item_ready,
    output trcfa_pkg::item_t                    item,
    output trcfa_pkg::cfg_t                     cfg
);
    import trcfa_pkg::*;

    cfg_t        cfg_reg;
    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.len_a      <= LEN_RESET;
            cfg_reg.len_b      <= LEN_RESET;
            cfg_reg.len_c      <= LEN_RESET;
            cfg_reg.trig_alpha <= TRIG_RESET;
            cfg_reg.trig_beta  <= TRIG_RESET;
            cfg_reg.trig_gamma <= TRIG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEN_A:      cfg_reg.len_a      <= cfg_data[31:0];
                CFG_LEN_B:      cfg_reg.len_b      <= cfg_data[31:0];
                CFG_LEN_C:      cfg_reg.len_c      <= cfg_data[31:0];
                CFG_TRIG_ALPHA: cfg_reg.trig_alpha <= cfg_data;
                CFG_TRIG_BETA:  cfg_reg.trig_beta  <= cfg_data;
                CFG_TRIG_GAMMA: cfg_reg.trig_gamma <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign in_ready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{frac_dx: frac_dx, frac_dy: frac_dy, frac_dz: frac_dz,
                                   target_sq: target_sq, weight: weight, last: last};
        end
    end

endmodule
`default_nettype wire

[hdl/trcfa_mul.sv]
`default_nettype none
module trcfa_mul (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [63:0]   a,
    input  wire logic signed [63:0]   b,
    input  wire trcfa_pkg::shift_t    sh,
    output logic                      done,
    output logic signed [63:0]        result
);
    import trcfa_pkg::*;

    mul_state_t        state_reg, state_next;
    logic [1:0]        cnt_reg;
    logic [63:0]       ux_reg, uy_reg;
    logic              neg_reg;
    shift_t            sh_reg;
    logic [127:0]      acc_reg;
    logic signed [63:0] res_reg;
    logic [31:0]       xs, ys;
    logic [63:0]       pp;
    logic [127:0]      pp_sh, rnd, q;
    logic signed [63:0] sat_val;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MS_IDLE:  if (start) state_next = MS_PROD;
            MS_PROD:  if (cnt_reg == 2'd3) state_next = MS_ROUND;
            MS_ROUND: state_next = MS_DONE;
            MS_DONE:  state_next = MS_IDLE;
            default:  state_next = MS_IDLE;
        endcase
    end

    always_comb
    begin
        done   = (state_reg == MS_DONE);
        result = res_reg;
    end

    // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
    always_comb
    begin
        xs = cnt_reg[1] ? ux_reg[63:32] : ux_reg[31:0];
        ys = (cnt_reg == 2'd1 || cnt_reg == 2'd3) ? uy_reg[63:32] : uy_reg[31:0];
        pp = 64'(xs) * 64'(ys);
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            SH24:    begin rnd = acc_reg + (128'd1 << 23); q = rnd >> 24; end
            SH26:    begin rnd = acc_reg + (128'd1 << 25); q = rnd >> 26; end
            SH28:    begin rnd = acc_reg + (128'd1 << 27); q = rnd >> 28; end
            default: begin rnd = acc_reg + (128'd1 << 29); q = rnd >> 30; end
        endcase
        if (q[127:63] != '0)
            sat_val = neg_reg ? S64_MIN : S64_MAX;
        else
            sat_val = neg_reg ? -$signed(q[63:0]) : $signed(q[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == MS_PROD)
                cnt_reg <= cnt_reg + 2'd1;
            else
                cnt_reg <= 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MS_IDLE && start)
        begin
            ux_reg  <= a[63] ? 64'(-a) : 64'(a);
            uy_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= sh;
            acc_reg <= '0;
        end
        else if (state_reg == MS_PROD)
            acc_reg <= acc_reg + pp_sh;
        if (state_reg == MS_ROUND)
            res_reg <= sat_val;
    end

endmodule
`default_nettype wire

[hdl/trcfa_back.sv]
`default_nettype none
module trcfa_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire trcfa_pkg::item_t     item,
    input  wire trcfa_pkg::cfg_t      cfg,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [63:0]        target_sum,
    output logic signed [63:0]        grad_a,
    output logic signed [63:0]        grad_b,
    output logic signed [63:0]        grad_c,
    output logic signed [63:0]        grad_alpha,
    output logic signed [63:0]        grad_beta,
    output logic signed [63:0]        grad_gamma
);
    import trcfa_pkg::*;

    back_state_t        state_reg, state_next;
    logic [5:0]         step_reg;
    item_t              item_reg;
    step_t              cur;
    logic signed [63:0] x_reg, y_reg, z_reg, xy_reg, xz_reg, yz_reg, d_reg, r_reg, wr_reg;
    logic signed [63:0] pa_reg, pb_reg, pc_reg;
    logic signed [63:0] dt_reg [6];
    logic signed [63:0] acct_reg;
    logic signed [63:0] accg_reg [6];
    logic signed [63:0] out_reg [7];
    logic               out_valid_reg, out_valid_next;
    logic signed [63:0] opa, opb, basev, p, pd, wb_val, r2;
    logic               mul_start, mul_done, wb_en, emit_go;

    function automatic logic signed [63:0] pick(input src_t s);
        logic signed [63:0] v;
        case (s)
            SRC_DX:    v = 64'(item_reg.frac_dx);
            SRC_DY:    v = 64'(item_reg.frac_dy);
            SRC_DZ:    v = 64'(item_reg.frac_dz);
            SRC_LA:    v = $signed({32'd0, cfg.len_a});
            SRC_LB:    v = $signed({32'd0, cfg.len_b});
            SRC_LC:    v = $signed({32'd0, cfg.len_c});
            SRC_CA:    v = 64'($signed(cfg.trig_alpha[63:32]));
            SRC_SA:    v = 64'($signed(cfg.trig_alpha[31:0]));
            SRC_CB:    v = 64'($signed(cfg.trig_beta[63:32]));
            SRC_SB:    v = 64'($signed(cfg.trig_beta[31:0]));
            SRC_CG:    v = 64'($signed(cfg.trig_gamma[63:32]));
            SRC_SG:    v = 64'($signed(cfg.trig_gamma[31:0]));
            SRC_W:     v = $signed({32'd0, item_reg.weight});
            SRC_X:     v = x_reg;
            SRC_Y:     v = y_reg;
            SRC_Z:     v = z_reg;
            SRC_XY:    v = xy_reg;
            SRC_XZ:    v = xz_reg;
            SRC_YZ:    v = yz_reg;
            SRC_D:     v = d_reg;
            SRC_R:     v = r_reg;
            SRC_WR:    v = wr_reg;
            SRC_PA:    v = pa_reg;
            SRC_PB:    v = pb_reg;
            SRC_PC:    v = pc_reg;
            SRC_DT0:   v = dt_reg[0];
            SRC_DT1:   v = dt_reg[1];
            SRC_DT2:   v = dt_reg[2];
            SRC_DT3:   v = dt_reg[3];
            SRC_DT4:   v = dt_reg[4];
            SRC_DT5:   v = dt_reg[5];
            SRC_ACCT:  v = acct_reg;
            SRC_ACCG0: v = accg_reg[0];
            SRC_ACCG1: v = accg_reg[1];
            SRC_ACCG2: v = accg_reg[2];
            SRC_ACCG3: v = accg_reg[3];
            SRC_ACCG4: v = accg_reg[4];
            SRC_ACCG5: v = accg_reg[5];
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign cur = step_rom(step_reg);

    trcfa_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (opa),
        .b      (opb),
        .sh     (cur.sh),
        .done   (mul_done),
        .result (p)
    );

    always_comb
    begin
        opa   = pick(cur.a);
        opb   = pick(cur.b);
        basev = pick(cur.base);
        r2    = $signed({20'd0, item_reg.target_sq, 12'd0});
        pd    = sat_dbl(p);
        case (cur.op)
            OP_SET:   wb_val = p;
            OP_SET2:  wb_val = pd;
            OP_NEG2:  wb_val = sat_neg(pd);
            OP_ADD:   wb_val = sat_add(basev, p);
            OP_ADD2:  wb_val = sat_add(basev, pd);
            default:  wb_val = sat_add(basev, -r2);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:  if (item_valid) state_next = BS_ISSUE;
            BS_ISSUE: if (cur.op != OP_SUBR2) state_next = BS_WAIT;
            BS_WAIT:  if (mul_done) state_next = BS_ISSUE;
            BS_EMIT:  if (emit_go) state_next = BS_IDLE;
            default:  state_next = BS_IDLE;
        endcase
        if (wb_en && step_reg == STEP_LAST)
            state_next = item_reg.last ? BS_EMIT : BS_IDLE;
    end

    always_comb
    begin
        item_ready = (state_reg == BS_IDLE);
        mul_start  = (state_reg == BS_ISSUE) && (cur.op != OP_SUBR2);
        wb_en      = ((state_reg == BS_ISSUE) && (cur.op == OP_SUBR2)) ||
                     ((state_reg == BS_WAIT) && mul_done);
        emit_go    = (state_reg == BS_EMIT) && (!out_valid_reg || out_ready);
        out_valid_next = emit_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
            acct_reg      <= '0;
            for (int k = 0; k < 6; k++)
                accg_reg[k] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (item_valid && item_ready)
                step_reg <= 6'd0;
            else if (wb_en)
                step_reg <= step_reg + 6'd1;
            // clear the sums once they are copied out
            if (emit_go)
            begin
                acct_reg <= '0;
                for (int k = 0; k < 6; k++)
                    accg_reg[k] <= '0;
            end
            else if (wb_en)
            begin
                case (cur.dst)
                    SRC_ACCT:  acct_reg    <= wb_val;
                    SRC_ACCG0: accg_reg[0] <= wb_val;
                    SRC_ACCG1: accg_reg[1] <= wb_val;
                    SRC_ACCG2: accg_reg[2] <= wb_val;
                    SRC_ACCG3: accg_reg[3] <= wb_val;
                    SRC_ACCG4: accg_reg[4] <= wb_val;
                    SRC_ACCG5: accg_reg[5] <= wb_val;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (wb_en)
        begin
            case (cur.dst)
                SRC_X:   x_reg     <= wb_val;
                SRC_Y:   y_reg     <= wb_val;
                SRC_Z:   z_reg     <= wb_val;
                SRC_XY:  xy_reg    <= wb_val;
                SRC_XZ:  xz_reg    <= wb_val;
                SRC_YZ:  yz_reg    <= wb_val;
                SRC_D:   d_reg     <= wb_val;
                SRC_R:   r_reg     <= wb_val;
                SRC_WR:  wr_reg    <= wb_val;
                SRC_PA:  pa_reg    <= wb_val;
                SRC_PB:  pb_reg    <= wb_val;
                SRC_PC:  pc_reg    <= wb_val;
                SRC_DT0: dt_reg[0] <= wb_val;
                SRC_DT1: dt_reg[1] <= wb_val;
                SRC_DT2: dt_reg[2] <= wb_val;
                SRC_DT3: dt_reg[3] <= wb_val;
                SRC_DT4: dt_reg[4] <= wb_val;
                SRC_DT5: dt_reg[5] <= wb_val;
                default: ;
            endcase
        end
        if (emit_go)
        begin
            out_reg[0] <= acct_reg;
            for (int k = 0; k < 6; k++)
                out_reg[k+1] <= accg_reg[k];
        end
    end

    assign out_valid  = out_valid_reg;
    assign target_sum = out_reg[0];
    assign grad_a     = out_reg[1];
    assign grad_b     = out_reg[2];
    assign grad_c     = out_reg[3];
    assign grad_alpha = out_reg[4];
    assign grad_beta  = out_reg[5];
    assign grad_gamma = out_reg[6];

endmodule
`default_nettype wire

[hdl/triclinic_cell_fit_accumulator.sv]
// Triclinic cell fit accumulator.
// Input channel (in_valid/in_ready) takes one distance restraint per item:
// fractional offsets, target squared distance, weight and a last flag.
// Config channel (cfg_valid/cfg_ready), always ready, writes cell lengths
// and packed cos/sin words by index; written while idle by user rule only.
// Output channel (out_valid/out_ready) gives the weighted squared residual
// sum and the six gradient sums once per set, after the item marked last.
// A two-item queue decouples intake from the compute sequencer, so items are
// taken while a result waits on the output register.
// Each item runs a 33-step microprogram on one shared 64x64 multiplier that
// walks four 32x32 partial products, then rounds and saturates. The
// sequencer takes the next item only once the current one is finished.
// Reset clears the queue, sums and output valid and restores the default
// cell. A stalled receiver holds the result; the sequencer waits only when
// a new result is ready and the previous one is still not taken.
`default_nettype none
module triclinic_cell_fit_accumulator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [31:0]              frac_dx,
    input  wire logic signed [31:0]              frac_dy,
    input  wire logic signed [31:0]              frac_dz,
    input  wire logic [31:0]                     target_sq,
    input  wire logic [31:0]                     weight,
    input  wire logic                            last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [trcfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                     cfg_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [63:0]                   target_sum,
    output logic signed [63:0]                   grad_a,
    output logic signed [63:0]                   grad_b,
    output logic signed [63:0]                   grad_c,
    output logic signed [63:0]                   grad_alpha,
    output logic signed [63:0]                   grad_beta,
    output logic signed [63:0]                   grad_gamma
);
    import trcfa_pkg::*;

    item_t item;
    cfg_t  cfg;
    logic  item_valid, item_ready;

    trcfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frac_dx    (frac_dx),
        .frac_dy    (frac_dy),
        .frac_dz    (frac_dz),
        .target_sq  (target_sq),
        .weight     (weight),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg)
    );

    trcfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .target_sum (target_sum),
        .grad_a     (grad_a),
        .grad_b     (grad_b),
        .grad_c     (grad_c),
        .grad_alpha (grad_alpha),
        .grad_beta  (grad_beta),
        .grad_gamma (grad_gamma)
    );

endmodule
`default_nettype wire

[hdl/trcfa_checker.sv]
`default_nettype none
module trcfa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cfg_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic signed [63:0]  target_sum,
    input wire logic signed [63:0]  grad_a
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(target_sum) && $stable(grad_a))
        else $error("result changed while stalled");

    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port blocked");

endmodule

bind triclinic_cell_fit_accumulator trcfa_checker u_trcfa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .target_sum (target_sum),
    .grad_a     (grad_a)
);
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
    import trcfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 800;

    typedef struct {
        bit                         is_reg;
        logic [CFG_IDX_W-1:0]       reg_idx;
        logic [63:0]                reg_val;
        item_t                      rst;
    } job_t;

    typedef struct {
        logic signed [63:0] tsum;
        logic signed [63:0] g [6];
    } sums_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic in_valid = 1'b0, in_ready;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [31:0] frac_dx = '0, frac_dy = '0, frac_dz = '0;
    logic [31:0] target_sq = '0, weight = '0;
    logic last = 1'b0;
    logic signed [63:0] target_sum, grad_a, grad_b, grad_c, grad_alpha, grad_beta, grad_gamma;

    job_t  pending [$];
    job_t  cur;
    sums_t sums_due [$];
    int    fail_count = 0;
    int    n_taken = 0;
    int    settle = 0;
    bit    settled = 0;
    int    quiet = 0;

    // predictor state
    logic [63:0] geom [6];
    logic signed [63:0] acc_t;
    logic signed [63:0] acc_g [6];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    triclinic_cell_fit_accumulator i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .frac_dx(frac_dx), .frac_dy(frac_dy), .frac_dz(frac_dz),
        .target_sq(target_sq), .weight(weight), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .target_sum(target_sum), .grad_a(grad_a), .grad_b(grad_b), .grad_c(grad_c),
        .grad_alpha(grad_alpha), .grad_beta(grad_beta), .grad_gamma(grad_gamma)
    );

    function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] qneg(input logic signed [63:0] a);
        if (a == S64_MIN) return S64_MAX;
        return -a;
    endfunction

    // product shifted right by sh, rounded half away from zero, saturated
    function automatic logic signed [63:0] qmul(input logic signed [63:0] x,
                                                input logic signed [63:0] y, input int sh);
        logic [63:0] ux, uy;
        logic [127:0] p;
        logic neg;
        neg = x[63] ^ y[63];
        ux = x[63] ? -x : x;
        uy = y[63] ? -y : y;
        p = {64'd0, ux} * {64'd0, uy};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (neg)
        begin
            if (p >= 128'h8000_0000_0000_0000) return S64_MIN;
            return -$signed(p[63:0]);
        end
        if (p > 128'h7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // fold one restraint into the sums; true when the set closes
    function automatic bit fold_restraint(input item_t it, output sums_t res);
        logic signed [63:0] dx, dy, dz, la, lb, lc, ca, sa, cb, sb, cg, sg;
        logic signed [63:0] X, Y, Z, XY, XZ, YZ, d, r, wr, pa, pb, pc;
        logic signed [63:0] dt [6];
        dx = sx32(it.frac_dx); dy = sx32(it.frac_dy); dz = sx32(it.frac_dz);
        la = {32'd0, geom[CFG_LEN_A][31:0]};
        lb = {32'd0, geom[CFG_LEN_B][31:0]};
        lc = {32'd0, geom[CFG_LEN_C][31:0]};
        ca = sx32(geom[CFG_TRIG_ALPHA][63:32]); sa = sx32(geom[CFG_TRIG_ALPHA][31:0]);
        cb = sx32(geom[CFG_TRIG_BETA][63:32]);  sb = sx32(geom[CFG_TRIG_BETA][31:0]);
        cg = sx32(geom[CFG_TRIG_GAMMA][63:32]); sg = sx32(geom[CFG_TRIG_GAMMA][31:0]);
        X = qmul(dx, la, 26); Y = qmul(dy, lb, 26); Z = qmul(dz, lc, 26);
        XY = qmul(X, Y, 24); XZ = qmul(X, Z, 24); YZ = qmul(Y, Z, 24);
        d = qadd(qmul(X, X, 24), qmul(Y, Y, 24));
        d = qadd(d, qmul(Z, Z, 24));
        d = qadd(d, qadd(qmul(XY, cg, 30), qmul(XY, cg, 30)));
        d = qadd(d, qadd(qmul(XZ, cb, 30), qmul(XZ, cb, 30)));
        d = qadd(d, qadd(qmul(YZ, ca, 30), qmul(YZ, ca, 30)));
        r = qadd(d, -$signed({20'd0, it.target_sq, 12'd0}));
        wr = qmul({32'd0, it.weight}, r, 24);
        pa = qadd(qadd(X, qmul(Y, cg, 30)), qmul(Z, cb, 30));
        pb = qadd(qadd(Y, qmul(X, cg, 30)), qmul(Z, ca, 30));
        pc = qadd(qadd(Z, qmul(X, cb, 30)), qmul(Y, ca, 30));
        dt[0] = qmul(dx, pa, 28); dt[1] = qmul(dy, pb, 28); dt[2] = qmul(dz, pc, 28);
        dt[3] = qmul(YZ, sa, 30); dt[4] = qmul(XZ, sb, 30); dt[5] = qmul(XY, sg, 30);
        for (int k = 0; k < 6; k++)
        begin
            dt[k] = qadd(dt[k], dt[k]);
            if (k >= 3) dt[k] = qneg(dt[k]);
        end
        acc_t = qadd(acc_t, qmul(wr, r, 24));
        for (int k = 0; k < 6; k++)
            acc_g[k] = qadd(acc_g[k], qadd(qmul(wr, dt[k], 24), qmul(wr, dt[k], 24)));
        res.tsum = acc_t;
        for (int k = 0; k < 6; k++) res.g[k] = acc_g[k];
        if (!it.last) return 0;
        acc_t = '0;
        for (int k = 0; k < 6; k++) acc_g[k] = '0;
        return 1;
    endfunction

    function automatic int idle_mode();
        return (n_taken / 160) % 4;
    endfunction

    // driver: items and register writes from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        bit stuck;
        bit hold_off;
        sums_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                n_taken++;
                if (fold_restraint(cur.rst, res)) sums_due.push_back(res);
            end
            if (cfg_valid && cfg_ready && cur.reg_idx < 6)
                geom[cur.reg_idx] = (cur.reg_idx < 3) ? {32'd0, cur.reg_val[31:0]} : cur.reg_val;
            stuck = (in_valid && !in_ready) || (cfg_valid && !cfg_ready);
            if (!stuck)
            begin
                hold_off = (idle_mode() == 1 && $urandom_range(99) < 64) ||
                           (idle_mode() == 3 && $urandom_range(99) < 37);
                if (settle > 0)
                begin
                    settle <= settle - 1;
                    in_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (pending.size() == 0 || hold_off)
                begin
                    in_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (pending[0].is_reg && !settled)
                begin
                    // drain the block before touching the cell
                    in_valid <= 1'b0;
                    cfg_valid <= 1'b0;
                    if (sums_due.size() == 0)
                    begin
                        settle <= SETTLE_CYCLES;
                        settled <= 1;
                    end
                end
                else
                begin
                    cur = pending.pop_front();
                    in_valid <= !cur.is_reg;
                    cfg_valid <= cur.is_reg;
                    if (cur.is_reg)
                    begin
                        cfg_index <= cur.reg_idx;
                        cfg_data <= cur.reg_val;
                    end
                    else
                    begin
                        settled <= 0;
                        frac_dx <= cur.rst.frac_dx;
                        frac_dy <= cur.rst.frac_dy;
                        frac_dz <= cur.rst.frac_dz;
                        target_sq <= cur.rst.target_sq;
                        weight <= cur.rst.weight;
                        last <= cur.rst.last;
                    end
                end
            end
        end
    end

    // monitor: check result items and drive the receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        sums_t want;
        logic signed [63:0] got [7];
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{target_sum, grad_a, grad_b, grad_c, grad_alpha, grad_beta, grad_gamma};
                if (sums_due.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (got[0] !== want.tsum)
                    begin
                        $error("target_sum: expected %0d, got %0d", want.tsum, got[0]);
                        fail_count++;
                    end
                    for (int k = 0; k < 6; k++)
                        if (got[k + 1] !== want.g[k])
                        begin
                            $error("%s: expected %0d, got %0d",
                                   k == 0 ? "grad_a" : k == 1 ? "grad_b" : k == 2 ? "grad_c" :
                                   k == 3 ? "grad_alpha" : k == 4 ? "grad_beta" : "grad_gamma",
                                   want.g[k], got[k + 1]);
                            fail_count++;
                        end
                end
            end
            case (idle_mode())
                2: out_ready <= $urandom_range(99) >= 64;
                3: out_ready <= $urandom_range(99) >= 37;
                default: out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_frac();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(32'h2000_0000) - 32'h1000_0000;
    endfunction

    task automatic add_restraint(input logic [31:0] dx, dy, dz, tgt, w, input bit fin);
        job_t j;
        j.is_reg = 0; j.reg_idx = '0; j.reg_val = '0;
        j.rst.frac_dx = dx; j.rst.frac_dy = dy; j.rst.frac_dz = dz;
        j.rst.target_sq = tgt; j.rst.weight = w; j.rst.last = fin;
        pending.push_back(j);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        job_t j;
        j.is_reg = 1; j.reg_idx = idx; j.reg_val = val; j.rst = '0;
        pending.push_back(j);
    endtask

    function automatic logic [63:0] trig_word();
        logic [31:0] c;
        logic [31:0] s;
        c = $urandom_range(32'h8000_0000) - 32'h4000_0000;
        s = $urandom_range(32'h4000_0000, 32'h2000_0000);
        if ($urandom_range(7) == 0) return {$urandom, $urandom};
        return {c, s};
    endfunction

    initial
    begin
        int n;
        #1 rst_n = 1'b0;
        geom[0] = {32'd0, LEN_RESET}; geom[1] = {32'd0, LEN_RESET}; geom[2] = {32'd0, LEN_RESET};
        geom[3] = TRIG_RESET; geom[4] = TRIG_RESET; geom[5] = TRIG_RESET;
        acc_t = '0;
        for (int k = 0; k < 6; k++) acc_g[k] = '0;

        // directed: zero item, field extremes, multi-item set, overflow
        add_restraint('0, '0, '0, '0, '0, 1);
        add_restraint(32'h1000_0000, '0, '0, '0, 32'h0100_0000, 1);
        add_restraint('0, 32'hF000_0000, 32'h1000_0000, 32'h0006_4000, 32'h0100_0000, 1);
        add_restraint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 32'hFFFF_FFFF, 1);
        add_restraint(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1, 1);
        add_restraint(32'h8000_0000, 32'h7FFF_FFFF, '0, '1, 32'h0000_0001, 1);
        add_restraint(32'h0800_0000, 32'h0400_0000, 32'h0200_0000, 32'h0001_0000, 32'h0100_0000, 0);
        add_restraint(32'hF800_0000, 32'h0400_0000, 32'hFE00_0000, 32'h0002_0000, 32'h0200_0000, 0);
        add_restraint(32'h0100_0000, 32'h0C00_0000, 32'h0300_0000, '1, 32'h0080_0000, 1);
        for (int i = 0; i < 6; i++)
            add_restraint(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '1, i == 5);
        add_restraint(32'h0555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 32'h5A5A_5A5A, 1);

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph > 0)
            begin
                for (int r = 0; r < 6; r++)
                begin
                    case (ph)
                        1: add_write(CFG_IDX_W'(r),
                                     r < 3 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_7FFF_FFFF);
                        2: add_write(CFG_IDX_W'(r), r < 3 ? 64'd0 : 64'h8000_0000_8000_0000);
                        3: add_write(CFG_IDX_W'(r), r < 3 ? 64'd0 : 64'd0);
                        default: add_write(CFG_IDX_W'(r), r < 3 ? {$urandom, 32'd0} |
                                           $urandom_range(32'h0780_0000, 32'h0080_0000)
                                           : trig_word());
                    endcase
                end
                // unused indexes must leave the cell alone
                add_write(CFG_IDX_W'(6), {$urandom, $urandom});
                add_write(CFG_IDX_W'(7), {$urandom, $urandom});
            end
            n = 0;
            while (n < 210)
            begin
                int len;
                len = ($urandom_range(19) == 0) ? 30 : $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    add_restraint(pick_frac(), pick_frac(), pick_frac(),
                                  $urandom_range(7) == 0 ? $urandom : $urandom_range(32'h0020_0000),
                                  $urandom_range(7) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                                  i == len - 1);
                n += len;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending.size() == 0);
        @(posedge clk);
        while (in_valid || cfg_valid || sums_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
